// File: src/assert_macros.svh
// Shared assertion macros; each samples on clk_i and is off while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/lsps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lsps_pkg;

  // Field widths
  localparam int unsigned GAIN_W    = 8;
  localparam int unsigned DRIVE_W   = 8;
  localparam int unsigned ERR_W     = 3;
  localparam int unsigned DIFF_W    = 4;
  localparam int unsigned CORR_W    = 21;
  localparam int unsigned CFG_IDX_W = 2;

  // Correction saturation bounds
  localparam logic signed [CORR_W-1:0] CORR_MAX = {1'b0, {(CORR_W-1){1'b1}}};
  localparam logic signed [CORR_W-1:0] CORR_MIN = {1'b1, {(CORR_W-1){1'b0}}};

  // Position error codes
  localparam logic signed [ERR_W-1:0] ERR_FAR  = 3'sd3;
  localparam logic signed [ERR_W-1:0] ERR_NEAR = 3'sd2;
  localparam logic signed [ERR_W-1:0] ERR_EDGE = 3'sd1;
  localparam logic signed [ERR_W-1:0] ERR_LOST = -3'sd1;

  // Sensor patterns, sensor a in the top bit
  localparam logic [2:0] PAT_NONE     = 3'b000;
  localparam logic [2:0] PAT_C        = 3'b001;
  localparam logic [2:0] PAT_BC       = 3'b011;
  localparam logic [2:0] PAT_A        = 3'b100;
  localparam logic [2:0] PAT_AB       = 3'b110;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_P     = 2'd0,
    CFG_GAIN_I     = 2'd1,
    CFG_GAIN_D     = 2'd2,
    CFG_BASE_SPEED = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [GAIN_W-1:0]  gain_p;
    logic [GAIN_W-1:0]  gain_i;
    logic [GAIN_W-1:0]  gain_d;
    logic [DRIVE_W-1:0] base_speed;
  } cfg_t;

  localparam cfg_t CFG_RST = '{gain_p: 8'd12, gain_i: 8'd0, gain_d: 8'd7,
                               base_speed: 8'd80};

endpackage

`default_nettype wire

// File: src/line_sensor_pid_steering.sv
// Throughput: one sample per cycle while m_axis_tready keeps the pipeline moving;
// the error and integral loop closes in the first stage.
// Four registered stages: error and integral, weighted products, sum, wheel drives.
// Reset: gains 12, 0, 7 and base speed 80; held error and integral cleared; pipeline empty.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module line_sensor_pid_steering import lsps_pkg::*; #(
  parameter int unsigned INTEGRAL_LIMIT = 4095
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // configuration write port
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [GAIN_W-1:0]    cfg_data_i,
  // sensor samples
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [7:0]           s_axis_tdata,  // sensor_a, sensor_b, sensor_c, zero pad
  // steering results
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic [39:0]               m_axis_tdata   // right_drive, left_drive, correction,
                                                   // error_value
);

  localparam int unsigned IntW = $clog2(INTEGRAL_LIMIT + 1) + 1;
  localparam logic signed [IntW-1:0] IntPos = IntW'(INTEGRAL_LIMIT);

  cfg_t                          cfg_q;
  logic                          en_a, en_b, en_c, en_d;
  logic                          va, vb, vc, vd;
  logic [2:0]                    pat;
  logic signed [ERR_W-1:0]       err_a, err_b, err_c, err_d;
  logic signed [DIFF_W-1:0]      diff_a;
  logic signed [IntW-1:0]        integ_a;
  logic signed [GAIN_W+ERR_W:0]  prod_p;
  logic signed [GAIN_W+IntW:0]   prod_i;
  logic signed [GAIN_W+DIFF_W:0] prod_d;
  logic signed [CORR_W-1:0]      corr_c, corr_d;
  logic [DRIVE_W-1:0]            right_d, left_d;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_GAIN_P:     cfg_q.gain_p     <= cfg_data_i;
        CFG_GAIN_I:     cfg_q.gain_i     <= cfg_data_i;
        CFG_GAIN_D:     cfg_q.gain_d     <= cfg_data_i;
        CFG_BASE_SPEED: cfg_q.base_speed <= cfg_data_i;
        default:        cfg_q            <= cfg_q;
      endcase
    end
  end

  // Advance each stage when it is empty or its successor moves
  assign en_d = !vd || m_axis_tready;
  assign en_c = !vc || en_d;
  assign en_b = !vb || en_c;
  assign en_a = !va || en_b;
  assign s_axis_tready = en_a;

  assign pat = {s_axis_tdata[0], s_axis_tdata[1], s_axis_tdata[2]};

  lsps_err_stage #(
    .IntegralLimit (INTEGRAL_LIMIT),
    .IntW          (IntW)
  ) u_err (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_a),
    .valid_i (s_axis_tvalid),
    .pat_i   (pat),
    .valid_o (va),
    .err_o   (err_a),
    .diff_o  (diff_a),
    .integ_o (integ_a)
  );

  lsps_mul_stage #(
    .IntW (IntW)
  ) u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en_b),
    .valid_i  (va),
    .cfg_i    (cfg_q),
    .err_i    (err_a),
    .diff_i   (diff_a),
    .integ_i  (integ_a),
    .valid_o  (vb),
    .err_o    (err_b),
    .prod_p_o (prod_p),
    .prod_i_o (prod_i),
    .prod_d_o (prod_d)
  );

  lsps_sum_stage #(
    .IntW (IntW)
  ) u_sum (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en_c),
    .valid_i  (vb),
    .err_i    (err_b),
    .prod_p_i (prod_p),
    .prod_i_i (prod_i),
    .prod_d_i (prod_d),
    .valid_o  (vc),
    .err_o    (err_c),
    .corr_o   (corr_c)
  );

  lsps_drive_stage u_drive (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_d),
    .valid_i (vc),
    .base_i  (cfg_q.base_speed),
    .err_i   (err_c),
    .corr_i  (corr_c),
    .valid_o (vd),
    .right_o (right_d),
    .left_o  (left_d),
    .corr_o  (corr_d),
    .err_o   (err_d)
  );

  assign m_axis_tvalid = vd;
  assign m_axis_tdata  = {err_d, corr_d, left_d, right_d};

  // Integral held inside its symmetric bound
  `ASSERT_IMPLIES(a_integ_bound, va, (integ_a <= IntPos) && (integ_a >= -IntPos),
    "integral outside its limit")
  // Error stays within the codes the decoder can produce
  `ASSERT_IMPLIES(a_err_range, vd, (err_d != -3'sd2) && (err_d != -3'sd3) && (err_d != -3'sd4),
    "error value out of range")
  // Zero correction leaves both wheels at base speed
  `ASSERT_IMPLIES(a_zero_corr, vd && (corr_d == '0),
    (right_d == cfg_q.base_speed) && (left_d == cfg_q.base_speed),
    "drives differ from base with zero correction")
  // An accepted sample always fills the first stage
  `ASSERT_NEXT(a_fill, s_axis_tvalid && s_axis_tready, va, "accepted sample lost")

endmodule

`default_nettype wire

// File: src/lsps_err_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module lsps_err_stage import lsps_pkg::*; #(
  parameter int unsigned IntegralLimit = 4095,
  parameter int unsigned IntW          = 13
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     en_i,
  input  wire logic                     valid_i,
  input  wire logic [2:0]               pat_i,
  output logic                          valid_o,
  output logic signed [ERR_W-1:0]       err_o,
  output logic signed [DIFF_W-1:0]      diff_o,
  output logic signed [IntW-1:0]        integ_o
);

  localparam int unsigned SumW = IntW + 1;
  localparam logic signed [SumW-1:0] LimPos = SumW'(IntegralLimit);
  localparam logic signed [SumW-1:0] LimNeg = -LimPos;

  logic                     valid_q;
  logic signed [ERR_W-1:0]  held_q, held_d;
  logic signed [IntW-1:0]   integral_q, integral_d;
  logic signed [ERR_W-1:0]  err_q;
  logic signed [DIFF_W-1:0] diff_q, diff_d;
  logic signed [IntW-1:0]   integ_q;
  logic signed [SumW-1:0]   int_sum;
  logic                     accept;

  assign accept = valid_i & en_i;

  // Map the sensor pattern to an error; other patterns hold the last one
  always_comb begin
    held_d = held_q;
    case (pat_i) inside
      PAT_A, PAT_AB: held_d = ERR_FAR;
      PAT_BC:        held_d = ERR_NEAR;
      PAT_C:         held_d = ERR_EDGE;
      PAT_NONE:      held_d = ERR_LOST;
      default:       held_d = held_q;
    endcase
  end

  // Accumulate and clamp the integral symmetrically
  always_comb begin
    int_sum = SumW'(integral_q) + SumW'(held_d);
    if (int_sum > LimPos) begin
      integral_d = IntW'(LimPos);
    end else if (int_sum < LimNeg) begin
      integral_d = IntW'(LimNeg);
    end else begin
      integral_d = IntW'(int_sum);
    end
    diff_d = DIFF_W'(held_d) - DIFF_W'(held_q);
  end

  // Update the loop state on every accepted request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q     <= '0;
      integral_q <= '0;
      valid_q    <= 1'b0;
    end else begin
      if (accept) begin
        held_q     <= held_d;
        integral_q <= integral_d;
      end
      if (en_i) begin
        valid_q <= valid_i;
      end
    end
  end

  // Stage payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      err_q   <= held_d;
      diff_q  <= diff_d;
      integ_q <= integral_d;
    end
  end

  assign valid_o = valid_q;
  assign err_o   = err_q;
  assign diff_o  = diff_q;
  assign integ_o = integ_q;

endmodule

`default_nettype wire

// File: src/lsps_mul_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module lsps_mul_stage import lsps_pkg::*; #(
  parameter int unsigned IntW = 13
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         en_i,
  input  wire logic                         valid_i,
  input  wire cfg_t                         cfg_i,
  input  wire logic signed [ERR_W-1:0]      err_i,
  input  wire logic signed [DIFF_W-1:0]     diff_i,
  input  wire logic signed [IntW-1:0]       integ_i,
  output logic                              valid_o,
  output logic signed [ERR_W-1:0]           err_o,
  output logic signed [GAIN_W+ERR_W:0]      prod_p_o,
  output logic signed [GAIN_W+IntW:0]       prod_i_o,
  output logic signed [GAIN_W+DIFF_W:0]     prod_d_o
);

  logic                             valid_q;
  logic signed [ERR_W-1:0]          err_q;
  logic signed [GAIN_W+ERR_W:0]     prod_p_q, prod_p_d;
  logic signed [GAIN_W+IntW:0]      prod_i_q, prod_i_d;
  logic signed [GAIN_W+DIFF_W:0]    prod_d_q, prod_d_d;

  // Weight each term by its unsigned gain
  assign prod_p_d = $signed({1'b0, cfg_i.gain_p}) * err_i;
  assign prod_i_d = $signed({1'b0, cfg_i.gain_i}) * integ_i;
  assign prod_d_d = $signed({1'b0, cfg_i.gain_d}) * diff_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      err_q    <= err_i;
      prod_p_q <= prod_p_d;
      prod_i_q <= prod_i_d;
      prod_d_q <= prod_d_d;
    end
  end

  assign valid_o  = valid_q;
  assign err_o    = err_q;
  assign prod_p_o = prod_p_q;
  assign prod_i_o = prod_i_q;
  assign prod_d_o = prod_d_q;

endmodule

`default_nettype wire

// File: src/lsps_sum_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module lsps_sum_stage import lsps_pkg::*; #(
  parameter int unsigned IntW = 13
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         en_i,
  input  wire logic                         valid_i,
  input  wire logic signed [ERR_W-1:0]      err_i,
  input  wire logic signed [GAIN_W+ERR_W:0] prod_p_i,
  input  wire logic signed [GAIN_W+IntW:0]  prod_i_i,
  input  wire logic signed [GAIN_W+DIFF_W:0] prod_d_i,
  output logic                              valid_o,
  output logic signed [ERR_W-1:0]           err_o,
  output logic signed [CORR_W-1:0]          corr_o
);

  // Wide enough for the three products and for the clamp bounds
  localparam int unsigned RawW = GAIN_W + IntW + 3;
  localparam int unsigned SumW = (RawW > CORR_W + 1) ? RawW : CORR_W + 1;
  localparam logic signed [SumW-1:0] SumMax = SumW'(CORR_MAX);
  localparam logic signed [SumW-1:0] SumMin = SumW'(CORR_MIN);

  logic                     valid_q;
  logic signed [ERR_W-1:0]  err_q;
  logic signed [CORR_W-1:0] corr_q, corr_d;
  logic signed [SumW-1:0]   sum;

  // Add the terms and clamp to the correction range
  always_comb begin
    sum = SumW'(prod_p_i) + SumW'(prod_i_i) + SumW'(prod_d_i);
    if (sum > SumMax) begin
      corr_d = CORR_MAX;
    end else if (sum < SumMin) begin
      corr_d = CORR_MIN;
    end else begin
      corr_d = CORR_W'(sum);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      err_q  <= err_i;
      corr_q <= corr_d;
    end
  end

  assign valid_o = valid_q;
  assign err_o   = err_q;
  assign corr_o  = corr_q;

endmodule

`default_nettype wire

// File: src/lsps_drive_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module lsps_drive_stage import lsps_pkg::*; (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         en_i,
  input  wire logic                         valid_i,
  input  wire logic [DRIVE_W-1:0]           base_i,
  input  wire logic signed [ERR_W-1:0]      err_i,
  input  wire logic signed [CORR_W-1:0]     corr_i,
  output logic                              valid_o,
  output logic [DRIVE_W-1:0]                right_o,
  output logic [DRIVE_W-1:0]                left_o,
  output logic signed [CORR_W-1:0]          corr_o,
  output logic signed [ERR_W-1:0]           err_o
);

  localparam int unsigned MixW = CORR_W + 2;
  localparam logic signed [MixW-1:0] DriveMax = MixW'({DRIVE_W{1'b1}});

  logic                     valid_q;
  logic [DRIVE_W-1:0]       right_q, right_d;
  logic [DRIVE_W-1:0]       left_q, left_d;
  logic signed [CORR_W-1:0] corr_q;
  logic signed [ERR_W-1:0]  err_q;
  logic signed [MixW-1:0]   base_ext;
  logic signed [MixW-1:0]   mix_r, mix_l;

  // Steer both wheels about the base level and clamp to the PWM range
  always_comb begin
    base_ext = $signed(MixW'(base_i));
    mix_r    = base_ext + MixW'(corr_i);
    mix_l    = base_ext - MixW'(corr_i);
    if (mix_r < 0) begin
      right_d = '0;
    end else if (mix_r > DriveMax) begin
      right_d = '1;
    end else begin
      right_d = DRIVE_W'(mix_r);
    end
    if (mix_l < 0) begin
      left_d = '0;
    end else if (mix_l > DriveMax) begin
      left_d = '1;
    end else begin
      left_d = DRIVE_W'(mix_l);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      right_q <= right_d;
      left_q  <= left_d;
      corr_q  <= corr_i;
      err_q   <= err_i;
    end
  end

  assign valid_o = valid_q;
  assign right_o = right_q;
  assign left_o  = left_q;
  assign corr_o  = corr_q;
  assign err_o   = err_q;

endmodule

`default_nettype wire
